// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define UCRD_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni pair.
`define UCRD_ASSERT(lbl, prop) \
  `UCRD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/ucrd_pkg.sv =====
package ucrd_pkg;

  // Fixed field widths of the item channels and the configuration port.
  localparam int SAMPLE_W   = 10;
  localparam int BH_W       = SAMPLE_W + 1;
  localparam int NOW_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Defaults for the top-level parameters.
  localparam int ADC_BITS_DEF = 10;
  localparam int CHANNELS_DEF = 2;

  // Register reset values and saturation limits.
  localparam logic [9:0] MNR_RST  = 10'd25;
  localparam logic [7:0] MRL_RST  = 8'd5;
  localparam logic [2:0] TMO_RST  = 3'd4;
  localparam logic [7:0] RUN_MAX  = 8'd255;
  localparam logic [2:0] TICK_MAX = 3'd7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MNR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MRL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TMO     = 3'd4;

  // Item kinds.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_CMD    = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Ranging commands.
  localparam logic [1:0] CMD_QUIET   = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_REFLECT = 2'd2;
  localparam logic [1:0] CMD_CONT    = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BAND    = 3'd1,
    EV_REPLY   = 3'd2,
    EV_RANGE   = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_CMD     = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    RM_QUIET     = 2'd0,
    RM_SENDER    = 2'd1,
    RM_REFLECTOR = 2'd2
  } rm_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample;
    logic [1:0]          command;
    logic [NOW_W-1:0]    now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          event_res;
    logic [NOW_W-1:0]    rtt_us;
    logic [SAMPLE_W-1:0] noise_low;
    logic [SAMPLE_W-1:0] noise_high;
    logic [1:0]          ranging_state;
    logic                tx_continuous;
  } out_item_t;

  typedef struct packed {
    logic       training_enable;
    logic       channel_select;
    logic [9:0] min_noise_range;
    logic [7:0] min_run_length;
    logic [2:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== design/ultrasound_chirp_ranging_detector.sv =====
// Items are held in the input register, results in the result register.
// Throughput: one item per cycle unless the output stalls; the core state
// updates as each item moves on, so each sees all the prior item left behind.
// Reset clears the configuration to its defaults, the noise store to untrained,
// the ranging mode to quiet and both pipeline stages to empty.
module ultrasound_chirp_ranging_detector
  import ucrd_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res, out_q;
  logic      out_vld_q;
  logic      out_free, fire;

  ucrd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: an item moves on when the result register is free or draining.
  assign out_free   = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  ucrd_core #(
    .ADC_BITS (ADC_BITS),
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_q),
    .fire_i (fire),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/ucrd_cfg.sv =====
module ucrd_cfg
  import ucrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Register file: one write per cycle, unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.training_enable <= 1'b0;
      cfg_q.channel_select  <= 1'b0;
      cfg_q.min_noise_range <= MNR_RST;
      cfg_q.min_run_length  <= MRL_RST;
      cfg_q.timeout_ticks   <= TMO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRAIN:   cfg_q.training_enable <= cfg_wdata_i[0];
        REG_CHANNEL: cfg_q.channel_select  <= cfg_wdata_i[0];
        REG_MNR:     cfg_q.min_noise_range <= cfg_wdata_i[9:0];
        REG_MRL:     cfg_q.min_run_length  <= cfg_wdata_i[7:0];
        REG_TMO:     cfg_q.timeout_ticks   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/ucrd_core.sv =====
module ucrd_core
  import ucrd_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  input  logic      fire_i,
  output out_item_t res_o
);

  localparam int AW   = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel noise limits and derived band.
  logic [AW-1:0]   nmin_q  [CHANNELS];
  logic [AW-1:0]   nmax_q  [CHANNELS];
  logic [AW-1:0]   blow_q  [CHANNELS];
  logic [BH_W-1:0] bhigh_q [CHANNELS];

  logic [7:0]       run_q, run_d, run_inc;
  rm_e              rm_q, rm_d;
  logic [NOW_W-1:0] send_q, send_d;
  logic [2:0]       tc_q, tc_d, tc_inc;
  logic             cont_q, cont_d;

  logic [CH_W-1:0]     ch;
  logic [AW-1:0]       s, cur_min, cur_max, new_min, new_max, span, blow_new;
  logic [SAMPLE_W-1:0] span_ext, rng, half, lo_ext;
  logic [BH_W-1:0]     bhigh_new;
  logic                untrained, in_band, band_we;
  event_e              ev;
  logic [NOW_W-1:0]    rtt;

  // Channel pick and sample masking.
  assign ch = (32'(cfg_i.channel_select) < CHANNELS) ? CH_W'(cfg_i.channel_select) : '0;
  assign s         = item_i.sample[AW-1:0];
  assign cur_min   = nmin_q[ch];
  assign cur_max   = nmax_q[ch];
  assign untrained = (cur_min == '0) && (cur_max == '0);
  assign in_band   = (SAMPLE_W'(s) >= SAMPLE_W'(blow_q[ch])) && (BH_W'(s) <= bhigh_q[ch]);

  // Band derivation from the updated limits; the low edge clamps at zero.
  assign span      = (new_max >= new_min) ? new_max - new_min : '0;
  assign span_ext  = SAMPLE_W'(span);
  assign rng       = (span_ext < cfg_i.min_noise_range) ? cfg_i.min_noise_range : span_ext;
  assign half      = rng >> 1;
  assign lo_ext    = SAMPLE_W'(new_min);
  assign blow_new  = (lo_ext >= half) ? AW'(lo_ext - half) : '0;
  assign bhigh_new = BH_W'(new_max) + BH_W'(half);

  // Saturating counters.
  assign run_inc = (run_q != RUN_MAX) ? run_q + 8'd1 : run_q;
  assign tc_inc  = (tc_q != TICK_MAX) ? tc_q + 3'd1 : tc_q;

  // Next state and result for the item at hand.
  always_comb begin
    ev      = EV_NONE;
    rtt     = '0;
    new_min = cur_min;
    new_max = cur_max;
    band_we = 1'b0;
    run_d   = run_q;
    rm_d    = rm_q;
    send_d  = send_q;
    tc_d    = tc_q;
    cont_d  = cont_q;
    case (item_i.mode)
      MODE_SAMPLE: begin
        if (cfg_i.training_enable) begin
          if (untrained) begin
            new_min = s;
            new_max = s;
            band_we = 1'b1;
          end else if (s < cur_min) begin
            new_min = s;
            band_we = 1'b1;
          end else if (s > cur_max) begin
            new_max = s;
            band_we = 1'b1;
          end
          if (band_we) begin
            ev = EV_BAND;
          end
        end else if (in_band) begin
          run_d = '0;
        end else if (run_inc > cfg_i.min_run_length) begin
          run_d = '0;
          if (rm_q == RM_REFLECTOR) begin
            cont_d = 1'b0;
            ev     = EV_REPLY;
          end else if (rm_q == RM_SENDER) begin
            rm_d = RM_QUIET;
            rtt  = item_i.now_us - send_q;
            ev   = EV_RANGE;
          end
        end else begin
          run_d = run_inc;
        end
      end
      MODE_CMD: begin
        case (item_i.command)
          CMD_QUIET: begin
            rm_d   = RM_QUIET;
            cont_d = 1'b0;
          end
          CMD_SEND: begin
            cont_d = 1'b0;
            send_d = item_i.now_us;
            tc_d   = '0;
            rm_d   = RM_SENDER;
          end
          CMD_REFLECT: rm_d = RM_REFLECTOR;
          default:     cont_d = 1'b1;
        endcase
        ev = EV_CMD;
      end
      MODE_TICK: begin
        if (rm_q == RM_SENDER) begin
          tc_d = tc_inc;
          if (tc_inc >= cfg_i.timeout_ticks) begin
            rm_d = RM_QUIET;
            ev   = EV_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per item that moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        nmin_q[i]  <= '0;
        nmax_q[i]  <= '0;
        blow_q[i]  <= '0;
        bhigh_q[i] <= '0;
      end
      run_q  <= '0;
      rm_q   <= RM_QUIET;
      send_q <= '0;
      tc_q   <= '0;
      cont_q <= 1'b0;
    end else if (fire_i) begin
      if (band_we) begin
        nmin_q[ch]  <= new_min;
        nmax_q[ch]  <= new_max;
        blow_q[ch]  <= blow_new;
        bhigh_q[ch] <= bhigh_new;
      end
      run_q  <= run_d;
      rm_q   <= rm_d;
      send_q <= send_d;
      tc_q   <= tc_d;
      cont_q <= cont_d;
    end
  end

  // Result fields; the noise limits are shown only with a band update.
  assign res_o.event_res     = ev;
  assign res_o.rtt_us        = rtt;
  assign res_o.noise_low     = (ev == EV_BAND) ? SAMPLE_W'(new_min) : '0;
  assign res_o.noise_high    = (ev == EV_BAND) ? SAMPLE_W'(new_max) : '0;
  assign res_o.ranging_state = rm_d;
  assign res_o.tx_continuous = cont_d;

endmodule

// ===== design/ucrd_checker.sv =====
`include "assert_macros.svh"

module ucrd_checker
  import ucrd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  logic ev_range, ev_timeout, ev_band, ev_reply;
  logic noise_zero, state_quiet, reply_ok;

  // Decoded fields of the result item on the output port.
  assign ev_range    = (out_item_o.event_res == EV_RANGE);
  assign ev_timeout  = (out_item_o.event_res == EV_TIMEOUT);
  assign ev_band     = (out_item_o.event_res == EV_BAND);
  assign ev_reply    = (out_item_o.event_res == EV_REPLY);
  assign noise_zero  = (out_item_o.noise_low == '0) && (out_item_o.noise_high == '0);
  assign state_quiet = (out_item_o.ranging_state == RM_QUIET);
  assign reply_ok    = (out_item_o.ranging_state == RM_REFLECTOR) && !out_item_o.tx_continuous;

  // A stalled result item holds.
  `UCRD_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))

  // Round-trip time appears only with a range measurement.
  `UCRD_ASSERT(a_rtt_only_range, (out_valid_o && !ev_range) |-> (out_item_o.rtt_us == '0))

  // Noise limits appear only with a band update.
  `UCRD_ASSERT(a_noise_only_band, (out_valid_o && !ev_band) |-> noise_zero)

  // A measurement or a timeout leaves the block quiet.
  `UCRD_ASSERT(a_quiet_after_end, (out_valid_o && (ev_range || ev_timeout)) |-> state_quiet)

  // A reply request comes only in reflector mode and stops continuous transmit.
  `UCRD_ASSERT(a_reply_reflector, (out_valid_o && ev_reply) |-> reply_ok)

endmodule

bind ultrasound_chirp_ranging_detector ucrd_checker u_ucrd_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  import ucrd_pkg::*;

  // Item kind that the block ignores.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Directed stimulus row: a configuration change or one item, optionally
  // with a hand-written expectation.
  typedef struct {
    logic      is_cfg;
    cfg_t      cfg;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_TRAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Shadow of the detector: configuration and state.
  cfg_t        model_cfg = '{1'b0, 1'b0, MNR_RST, MRL_RST, TMO_RST};
  logic [9:0]  noise_min [2] = '{default: '0};
  logic [9:0]  noise_max [2] = '{default: '0};
  logic [9:0]  band_low  [2] = '{default: '0};
  logic [10:0] band_high [2] = '{default: '0};
  logic [7:0]  run_len   = '0;
  rm_e         range_mode = RM_QUIET;
  logic [31:0] send_stamp = '0;
  logic [2:0]  tick_count = '0;
  logic        cont_tx    = 1'b0;

  out_item_t   expected_results [$];
  plan_row_t   plan [$];
  logic [31:0] clock_us;
  logic [9:0]  noise_center [2];
  int          items_sent    = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          rx_stall_pct  = 0;
  int          hold_left     = 0;
  logic        holdoff_req   = 1'b0;

  ultrasound_chirp_ranging_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  // Computes the result of one item and advances the shadow state.
  function automatic out_item_t ranging_outcome(input in_item_t it);
    out_item_t  r;
    int         ch;
    logic [9:0] rng;
    logic [9:0] half;
    r  = '0;
    ch = int'(model_cfg.channel_select);
    case (it.mode)
      MODE_SAMPLE: begin
        if (model_cfg.training_enable) begin
          // An untrained channel takes the sample as both extremes.
          if (noise_min[ch] == '0 && noise_max[ch] == '0) begin
            noise_min[ch] = it.sample;
            noise_max[ch] = it.sample;
            r.event_res   = EV_BAND;
          end else if (it.sample < noise_min[ch]) begin
            noise_min[ch] = it.sample;
            r.event_res   = EV_BAND;
          end else if (it.sample > noise_max[ch]) begin
            noise_max[ch] = it.sample;
            r.event_res   = EV_BAND;
          end
          if (r.event_res == EV_BAND) begin
            rng = (noise_max[ch] >= noise_min[ch]) ? noise_max[ch] - noise_min[ch] : '0;
            if (rng < model_cfg.min_noise_range) rng = model_cfg.min_noise_range;
            half = rng >> 1;
            // The lower edge saturates at zero.
            band_low[ch]  = (noise_min[ch] >= half) ? noise_min[ch] - half : '0;
            band_high[ch] = {1'b0, noise_max[ch]} + {1'b0, half};
            r.noise_low   = noise_min[ch];
            r.noise_high  = noise_max[ch];
          end
        end else if (it.sample >= band_low[ch] && {1'b0, it.sample} <= band_high[ch]) begin
          run_len = '0;
        end else begin
          if (run_len != RUN_MAX) run_len = run_len + 8'd1;
          if (run_len > model_cfg.min_run_length) begin
            run_len = '0;
            if (range_mode == RM_REFLECTOR) begin
              cont_tx     = 1'b0;
              r.event_res = EV_REPLY;
            end else if (range_mode == RM_SENDER) begin
              range_mode  = RM_QUIET;
              r.rtt_us    = it.now_us - send_stamp;
              r.event_res = EV_RANGE;
            end
          end
        end
      end
      MODE_CMD: begin
        case (it.command)
          CMD_QUIET: begin
            range_mode = RM_QUIET;
            cont_tx    = 1'b0;
          end
          CMD_SEND: begin
            cont_tx    = 1'b0;
            send_stamp = it.now_us;
            tick_count = '0;
            range_mode = RM_SENDER;
          end
          CMD_REFLECT: range_mode = RM_REFLECTOR;
          default:     cont_tx = 1'b1;
        endcase
        r.event_res = EV_CMD;
      end
      MODE_TICK: begin
        if (range_mode == RM_SENDER) begin
          if (tick_count != TICK_MAX) tick_count = tick_count + 3'd1;
          if (tick_count >= model_cfg.timeout_ticks) begin
            range_mode  = RM_QUIET;
            r.event_res = EV_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.ranging_state = range_mode;
    r.tx_continuous = cont_tx;
    return r;
  endfunction

  function automatic out_item_t outcome(input event_e ev, input logic [31:0] rtt,
                                        input logic [9:0] lo, input logic [9:0] hi,
                                        input rm_e rm, input logic cont);
    out_item_t r;
    r = '{ev, rtt, lo, hi, rm, cont};
    return r;
  endfunction

  function automatic void plan_step(input logic [1:0] md, input logic [9:0] s,
                                    input logic [1:0] cmd, input logic [31:0] t,
                                    input logic typed, input out_item_t want);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cfg    = '0;
    row.item   = '{md, s, cmd, t};
    row.typed  = typed;
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input cfg_t c);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.cfg    = c;
    row.item   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  // Random timestamp that mostly advances and sometimes jumps anywhere.
  function automatic in_item_t next_item(input logic [1:0] md, input logic [9:0] s,
                                         input logic [1:0] cmd);
    in_item_t it;
    if ($urandom_range(0, 15) == 0) clock_us = $urandom();
    else clock_us = clock_us + $urandom_range(1, 2000);
    it = '{md, s, cmd, clock_us};
    return it;
  endfunction

  // Picks a sample inside or outside the band of the selected channel.
  function automatic logic [9:0] band_sample(input logic outside);
    int ch;
    int lo;
    int hi;
    ch = int'(model_cfg.channel_select);
    lo = int'(band_low[ch]);
    hi = (band_high[ch] > 11'd1023) ? 1023 : int'(band_high[ch]);
    if (!outside) return 10'($urandom_range(hi, lo));
    if (band_high[ch] < 11'd1023 && (lo == 0 || $urandom_range(0, 1) == 1))
      return 10'($urandom_range(1023, band_high[ch] + 1));
    if (lo > 0) return 10'($urandom_range(lo - 1, 0));
    return 10'($urandom());
  endfunction

  // Offers one item, holds it until accepted, then records its expectation.
  task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = ranging_outcome(it);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Registers change only with the pipeline empty.
  task automatic apply_config(input cfg_t c);
    wait_all_results();
    write_reg(REG_TRAIN,   CFG_DATA_W'(c.training_enable));
    write_reg(REG_CHANNEL, CFG_DATA_W'(c.channel_select));
    write_reg(REG_MNR,     CFG_DATA_W'(c.min_noise_range));
    write_reg(REG_MRL,     CFG_DATA_W'(c.min_run_length));
    write_reg(REG_TMO,     CFG_DATA_W'(c.timeout_ticks));
    cfg_we_i  <= 1'b0;
    model_cfg = c;
  endtask

  // One ranging session: train a channel, then detect with commands, ticks,
  // chirp-length bursts, in-band noise and stray items mixed in.
  task automatic ranging_session();
    cfg_t       c;
    int         ch;
    int         n;
    int         kind;
    int         burst;
    logic [1:0] cmd;
    c  = model_cfg;
    ch = $urandom_range(0, 1);
    c.training_enable = 1'b1;
    c.channel_select  = 1'(ch);
    case ($urandom_range(0, 5))
      0:       c.min_noise_range = 10'd0;
      1:       c.min_noise_range = 10'd1023;
      default: c.min_noise_range = 10'($urandom_range(0, 80));
    endcase
    apply_config(c);
    repeat ($urandom_range(2, 8))
      offer_item(next_item(MODE_SAMPLE,
                           10'(int'(noise_center[ch]) + $urandom_range(0, 40) - 20),
                           2'($urandom())), 1'b0, '0);

    c.training_enable = 1'b0;
    if ($urandom_range(0, 4) == 0) c.channel_select = ~c.channel_select;
    case ($urandom_range(0, 7))
      0:       c.min_run_length = 8'd0;
      1:       c.min_run_length = 8'd255;
      default: c.min_run_length = 8'($urandom_range(1, 6));
    endcase
    c.timeout_ticks = 3'($urandom_range(0, 7));
    apply_config(c);

    offer_item(next_item(MODE_CMD, 10'($urandom()),
                         $urandom_range(0, 1) ? CMD_SEND : CMD_REFLECT), 1'b0, '0);
    n = $urandom_range(25, 45);
    while (n > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        case ($urandom_range(0, 99) / 25)
          0, 1:    cmd = CMD_SEND;
          2:       cmd = CMD_REFLECT;
          default: cmd = $urandom_range(0, 1) ? CMD_QUIET : CMD_CONT;
        endcase
        offer_item(next_item(MODE_CMD, 10'($urandom()), cmd), 1'b0, '0);
        n--;
      end else if (kind < 18) begin
        offer_item(next_item(MODE_TICK, 10'($urandom()), 2'($urandom())), 1'b0, '0);
        n--;
      end else if (kind < 21) begin
        offer_item(next_item(MODE_SPARE, 10'($urandom()), 2'($urandom())), 1'b0, '0);
        n--;
      end else if (kind < 45) begin
        // Runs around the chirp length: just short, just enough, one more.
        burst = (model_cfg.min_run_length < 8) ?
                model_cfg.min_run_length + $urandom_range(0, 2) : $urandom_range(1, 10);
        if (burst == 0) burst = 1;
        repeat (burst)
          offer_item(next_item(MODE_SAMPLE, band_sample(1'b1), 2'($urandom())), 1'b0, '0);
        n -= burst;
      end else begin
        offer_item(next_item(MODE_SAMPLE,
                             ($urandom_range(0, 3) == 0) ? 10'($urandom()) : band_sample(1'b0),
                             2'($urandom())), 1'b0, '0);
        n--;
      end
    end
  endtask

  // Receive side: check each result, then decide the next ready value.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no item pending: event %0d", $time,
                   out_item_o.event_res);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.event_res !== want.event_res || out_item_o.rtt_us !== want.rtt_us ||
            out_item_o.noise_low !== want.noise_low ||
            out_item_o.noise_high !== want.noise_high ||
            out_item_o.ranging_state !== want.ranging_state ||
            out_item_o.tx_continuous !== want.tx_continuous) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] mismatch exp/act: event %0d/%0d rtt %0h/%0h low %0d/%0d",
                     $time, want.event_res, out_item_o.event_res, want.rtt_us,
                     out_item_o.rtt_us, want.noise_low, out_item_o.noise_low);
            $display("[%0t]   high %0d/%0d state %0d/%0d cont %0b/%0b", $time,
                     want.noise_high, out_item_o.noise_high, want.ranging_state,
                     out_item_o.ranging_state, want.tx_continuous,
                     out_item_o.tx_continuous);
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      hold_left   = 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Main sequence.
  initial begin
    int   idle_in  [4];
    int   idle_out [4];
    int   phase_start;
    cfg_t c;
    idle_in  = '{0, 51, 0, 16};
    idle_out = '{0, 0, 51, 16};
    clock_us = $urandom();
    noise_center[0] = 10'($urandom_range(300, 700));
    noise_center[1] = 10'd25;

    // Directed part. Defaults after reset: detect mode, band of channel 0 is [0,0].
    plan_step(MODE_TICK, 10'd0, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_NONE, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));
    plan_step(MODE_SPARE, 10'd1023, CMD_CONT, 32'hFFFF_FFFF, 1'b1,
              outcome(EV_NONE, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));
    plan_step(MODE_CMD, 10'd0, CMD_CONT, 32'd1, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b1));
    plan_step(MODE_CMD, 10'd0, CMD_REFLECT, 32'd2, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_REFLECTOR, 1'b1));
    // Six out-of-band samples: the sixth passes the run length and asks for a reply,
    // which also stops continuous transmit.
    repeat (5) plan_step(MODE_SAMPLE, 10'd1023, CMD_QUIET, 32'd3, 1'b0, '0);
    plan_step(MODE_SAMPLE, 10'd1023, CMD_QUIET, 32'd4, 1'b1,
              outcome(EV_REPLY, 32'd0, 10'd0, 10'd0, RM_REFLECTOR, 1'b0));
    plan_step(MODE_CMD, 10'd0, CMD_SEND, 32'h10, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_SENDER, 1'b0));
    repeat (3) plan_step(MODE_TICK, 10'd0, CMD_QUIET, 32'h20, 1'b0, '0);
    plan_step(MODE_TICK, 10'd0, CMD_QUIET, 32'h30, 1'b1,
              outcome(EV_TIMEOUT, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));

    // Training channel 1 with the widest minimum range; the lower edge saturates.
    plan_cfg('{1'b1, 1'b1, 10'd1023, 8'd5, 3'd4});
    plan_step(MODE_SAMPLE, 10'd0, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_BAND, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));
    plan_step(MODE_SAMPLE, 10'd20, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_BAND, 32'd0, 10'd20, 10'd20, RM_QUIET, 1'b0));
    plan_step(MODE_SAMPLE, 10'd10, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_BAND, 32'd0, 10'd10, 10'd20, RM_QUIET, 1'b0));
    plan_step(MODE_SAMPLE, 10'd40, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_BAND, 32'd0, 10'd10, 10'd40, RM_QUIET, 1'b0));
    plan_step(MODE_SAMPLE, 10'd30, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_NONE, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));

    // Zero run length and zero timeout on channel 0.
    plan_cfg('{1'b0, 1'b0, 10'd0, 8'd0, 3'd0});
    plan_step(MODE_CMD, 10'd0, CMD_CONT, 32'd0, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b1));
    plan_step(MODE_CMD, 10'd0, CMD_SEND, 32'd5, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_SENDER, 1'b0));
    // Timestamp wraps: 2 - 5 modulo 2^32.
    plan_step(MODE_SAMPLE, 10'd1, CMD_QUIET, 32'd2, 1'b1,
              outcome(EV_RANGE, 32'hFFFF_FFFD, 10'd0, 10'd0, RM_QUIET, 1'b0));
    plan_step(MODE_CMD, 10'd0, CMD_SEND, 32'd0, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_SENDER, 1'b0));
    plan_step(MODE_TICK, 10'd0, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_TIMEOUT, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));
    // A chirp while quiet only clears the run.
    plan_step(MODE_SAMPLE, 10'd1, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_NONE, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));
    plan_step(MODE_CMD, 10'd0, CMD_CONT, 32'd0, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b1));
    plan_step(MODE_CMD, 10'd0, CMD_QUIET, 32'd0, 1'b1,
              outcome(EV_CMD, 32'd0, 10'd0, 10'd0, RM_QUIET, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) apply_config(plan[i].cfg);
      else offer_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Run saturation: 260 out-of-band samples with the longest run length,
    // then one more after lowering it must still see a full run and range.
    // The receiver holds off meanwhile so the block backs up.
    c = '{1'b0, 1'b1, 10'd25, 8'd255, 3'd7};
    apply_config(c);
    offer_item(next_item(MODE_CMD, 10'($urandom()), CMD_SEND), 1'b0, '0);
    holdoff_req = 1'b1;
    repeat (260)
      offer_item(next_item(MODE_SAMPLE, band_sample(1'b1), 2'($urandom())), 1'b0, '0);
    c.min_run_length = 8'd254;
    apply_config(c);
    offer_item(next_item(MODE_SAMPLE, band_sample(1'b1), 2'($urandom())), 1'b0, '0);

    // Random sessions under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_in[p];
      rx_stall_pct  = idle_out[p];
      phase_start   = items_sent;
      while (items_sent - phase_start < 70) ranging_session();
    end

    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
